/* src/whva_pkg.sv */
// Shared constants and types for the windowed hand velocity averager.
// No dependencies; imported by whva_if, whva_lane and the top level.
package whva_pkg;

  localparam int NUM_AXES   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0]  REG_TRACK_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_WINDOW_LEN   = 2'd1;
  localparam logic [CFG_DATA_W-1:0] WINDOW_LEN_RST   = 7'd15;

  typedef struct packed {
    logic clear;
    logic load;
    logic upd;
    logic start;
    logic track;
    logic hand;
    logic old_valid;
  } lane_ctl_t;

endpackage

/* src/whva_if.sv */
// Handshake channel interfaces: hand item input, velocity result output, register writes.
// Depends on whva_pkg for the register port widths.
interface whva_in_if #(parameter int POS_WIDTH = 20);
  logic                        valid;
  logic                        ready;
  logic                        hand_present;
  logic                        is_left;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] pos_z;
  logic                        end_of_frame;

  modport source (output valid, hand_present, is_left, pos_x, pos_y, pos_z, end_of_frame,
                  input ready);
  modport sink   (input valid, hand_present, is_left, pos_x, pos_y, pos_z, end_of_frame,
                  output ready);
endinterface

interface whva_out_if #(parameter int POS_WIDTH = 20);
  logic                      valid;
  logic                      ready;
  logic                      hand_side;
  logic signed [POS_WIDTH:0] vel_x;
  logic signed [POS_WIDTH:0] vel_y;
  logic signed [POS_WIDTH:0] vel_z;

  modport source (output valid, hand_side, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, hand_side, vel_x, vel_y, vel_z, output ready);
endinterface

interface whva_cfg_if;
  import whva_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/whva_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module whva_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* src/whva_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; used by whva_lane.
module whva_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  always_comb begin
    trial     = {rem_r, quo_r[NUM_W-1]};
    ge        = (trial >= {1'b0, den});
    trial_sub = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
      rem_r  <= '0;
      quo_r  <= num;
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

/* src/whva_lane.sv */
// One axis lane: difference ring, per-hand previous position and running sum, rounded divide.
// Depends on whva_pkg, whva_ram and whva_div.
module whva_lane #(
  parameter int POS_WIDTH  = 20,
  parameter int MAX_WINDOW = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  whva_pkg::lane_ctl_t                  ctl,
  input  logic [$clog2(MAX_WINDOW):0]          addr,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]      len,
  input  logic signed [POS_WIDTH-1:0]          pos,
  output logic                                 busy,
  output logic signed [POS_WIDTH:0]            vel
);
  import whva_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int DIFF_W = POS_WIDTH + 1;
  localparam int SUM_W  = POS_WIDTH + IDX_W + 1;
  localparam int MAG_W  = SUM_W - 1;
  localparam int VEL_W  = POS_WIDTH + 1;

  logic signed [POS_WIDTH-1:0] pos_r;
  logic signed [POS_WIDTH-1:0] prev_r [2];
  logic signed [SUM_W-1:0]     sum_r [2];
  logic signed [SUM_W-1:0]     cur_sum_r;
  logic                        neg_r;

  logic [DIFF_W-1:0] rd_data;
  logic [DIFF_W-1:0] old_diff;
  logic [DIFF_W-1:0] diff;
  logic [SUM_W-1:0]  new_sum;
  logic [SUM_W-1:0]  abs_sum;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  quo;
  logic [MAG_W-1:0]  quo_signed;

  whva_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ctl.upd && ctl.track),
    .wr_addr (addr),
    .wr_data (diff),
    .rd_en   (ctl.load),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_comb begin
    old_diff = ctl.old_valid ? rd_data : '0;
    diff     = {pos_r[POS_WIDTH-1], pos_r}
             - {prev_r[ctl.hand][POS_WIDTH-1], prev_r[ctl.hand]};
    new_sum  = sum_r[ctl.hand]
             + {{(SUM_W-DIFF_W){diff[DIFF_W-1]}}, diff}
             - {{(SUM_W-DIFF_W){old_diff[DIFF_W-1]}}, old_diff};
    abs_sum  = cur_sum_r[SUM_W-1] ? (~cur_sum_r + SUM_W'(1)) : cur_sum_r;
    mag      = abs_sum[MAG_W-1:0] + MAG_W'(len >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      prev_r[0] <= '0;
      prev_r[1] <= '0;
      sum_r[0]  <= '0;
      sum_r[1]  <= '0;
    end else if (ctl.upd && ctl.track) begin
      prev_r[ctl.hand] <= pos_r;
      sum_r[ctl.hand]  <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos_r <= pos;
    end
    if (ctl.upd) begin
      cur_sum_r <= ctl.track ? new_sum : sum_r[ctl.hand];
    end
    if (ctl.start) begin
      neg_r <= cur_sum_r[SUM_W-1];
    end
  end

  whva_div #(
    .NUM_W (MAG_W),
    .DEN_W (LEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.start),
    .num   (mag),
    .den   (len),
    .busy  (busy),
    .quo   (quo)
  );

  assign quo_signed = neg_r ? (~quo + MAG_W'(1)) : quo;
  assign vel        = quo_signed[VEL_W-1:0];

endmodule

/* src/windowed_hand_velocity_averager_top.sv */
// Top level of the windowed hand velocity averager: control, valid bits, lanes, result register.
// Depends on whva_pkg, the whva_*_if interfaces and whva_lane.
//
// Usage:
//   in_if   hand item beats: optional palm position of one hand plus an end-of-frame mark.
//   out_if  one velocity beat per item with hand_present set; none for other items.
//   cfg_if  register writes (track_enable, window_len); always ready, write only when idle.
//           A write to a known register invalidates ring entries and clears sums, previous positions and index.
// Flow: a hand item passes through S_UPD, S_START and the divide in S_DIV before its result
//   is registered; the divide time is set by the bit-serial divider in each axis lane.
// A new item is taken only in S_IDLE, so a hand item is not accepted until the previous
//   result has been loaded; an item without a hand is taken without leaving S_IDLE.
// Ring read happens on the accept cycle, write-back on the next, then the divide runs.
// Reset: synchronous, active low; clears state, track_enable to 0, window_len to 15.
// Receiver stall: the result register holds its beat; the next item is still accepted
//   and processed, and waits at the end of its divide until the register frees up.
module windowed_hand_velocity_averager_top #(
  parameter int MAX_WINDOW = 64,
  parameter int POS_WIDTH  = 20
) (
  input logic      clk,
  input logic      rst_n,
  whva_in_if.sink  in_if,
  whva_out_if.source out_if,
  whva_cfg_if.sink cfg_if
);
  import whva_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_START,
    S_DIV,
    S_HOLD
  } state_t;

  state_t                  state_r;
  logic                    track_r;
  logic [CFG_DATA_W-1:0]   window_len_r;
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W-1:0]        idx_nxt;
  logic [DEPTH-1:0]        valid_r;
  logic [ADDR_W-1:0]       slot_r;
  logic                    hand_r;
  logic                    out_valid_r;
  logic                    out_side_r;
  logic signed [POS_WIDTH:0] out_vel_r [NUM_AXES];

  logic                    in_acc;
  logic                    hand_acc;
  logic                    cfg_acc;
  logic                    cfg_hit;
  logic                    out_free;
  logic                    out_load;
  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        idx_inc;
  logic [ADDR_W-1:0]       lane_addr;
  lane_ctl_t               lane_ctl;
  logic [NUM_AXES-1:0]     lane_busy;
  logic signed [POS_WIDTH-1:0] lane_pos [NUM_AXES];
  logic signed [POS_WIDTH:0]   lane_vel [NUM_AXES];

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign in_acc   = in_if.valid && in_if.ready;
  assign hand_acc = in_acc && in_if.hand_present;
  assign cfg_acc  = cfg_if.valid && cfg_if.ready;
  assign cfg_hit  = cfg_acc && ((cfg_if.index == REG_TRACK_ENABLE) ||
                                (cfg_if.index == REG_WINDOW_LEN));
  assign out_free = !out_valid_r || out_if.ready;
  assign out_load = ((state_r == S_DIV) || (state_r == S_HOLD)) && (lane_busy == '0) &&
                    out_free;

  always_comb begin
    if (window_len_r == '0) begin
      len = LEN_W'(1);
    end else if (32'(window_len_r) > 32'(MAX_WINDOW)) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(window_len_r);
    end
    idx_inc = LEN_W'(idx_r) + LEN_W'(1);
    idx_nxt = (idx_inc >= len) ? '0 : idx_inc[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r      <= 1'b0;
      window_len_r <= WINDOW_LEN_RST;
      idx_r        <= '0;
      valid_r      <= '0;
    end else if (cfg_hit) begin
      if (cfg_if.index == REG_TRACK_ENABLE) begin
        track_r <= cfg_if.data[0];
      end else begin
        window_len_r <= cfg_if.data;
      end
      idx_r   <= '0;
      valid_r <= '0;
    end else begin
      if (in_acc && track_r && in_if.end_of_frame) begin
        idx_r <= idx_nxt;
      end
      if (state_r == S_UPD && track_r) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hand_acc) begin
      slot_r <= {in_if.is_left, idx_r};
      hand_r <= in_if.is_left;
    end
  end

  always_comb begin
    lane_ctl.clear     = cfg_hit;
    lane_ctl.load      = hand_acc;
    lane_ctl.upd       = (state_r == S_UPD);
    lane_ctl.start     = (state_r == S_START);
    lane_ctl.track     = track_r;
    lane_ctl.hand      = hand_r;
    lane_ctl.old_valid = valid_r[slot_r];
    lane_addr          = (state_r == S_IDLE) ? {in_if.is_left, idx_r} : slot_r;
  end

  assign lane_pos[0] = in_if.pos_x;
  assign lane_pos[1] = in_if.pos_y;
  assign lane_pos[2] = in_if.pos_z;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    whva_lane #(
      .POS_WIDTH  (POS_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl),
      .addr  (lane_addr),
      .len   (len),
      .pos   (lane_pos[g]),
      .busy  (lane_busy[g]),
      .vel   (lane_vel[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (hand_acc) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV, S_HOLD: begin
          if (lane_busy == '0) begin
            if (out_free) begin
              out_side_r  <= hand_r;
              for (int a = 0; a < NUM_AXES; a++) begin
                out_vel_r[a] <= lane_vel[a];
              end
              state_r <= S_IDLE;
            end else begin
              state_r <= S_HOLD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.hand_side = out_side_r;
  assign out_if.vel_x     = out_vel_r[0];
  assign out_if.vel_y     = out_vel_r[1];
  assign out_if.vel_z     = out_vel_r[2];

`ifndef SYNTHESIS
  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_busy[0] == lane_busy[1]) && (lane_busy[0] == lane_busy[2]))
    else $error("axis lanes out of step");

  a_index_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(idx_r) < len)
    else $error("window index beyond window length");

  a_hand_beat_updates: assert property (@(posedge clk) disable iff (!rst_n)
    hand_acc |=> (state_r == S_UPD))
    else $error("hand beat did not start an update");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (idx_r == '0) && (valid_r == '0))
    else $error("register write did not clear window state");
`endif

endmodule
